// File: src/bliu_pkg.sv
// Package for the bilinear image upscaler.
// Operation codes, register indexes and fixed-point constants; no dependencies.
`timescale 1ns / 1ps
package bliu_pkg;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_STEP_X     = 3'd2,
    REG_STEP_Y     = 3'd3,
    REG_CHANNELS   = 3'd4
  } reg_idx_e;

  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned STEP_W  = 17;
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned COORD_W = 12;
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;
  localparam logic [7:0]  PIX_MAX    = 8'd255;
  localparam logic [2:0]  RGB_CHANNELS = 3'd3;

endpackage

// File: src/bliu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bliu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bliu_locate.sv
// One axis of the coordinate mapping: step * coordinate, then neighbor split.
// Two register stages; uses bliu_pkg.
`timescale 1ns / 1ps
module bliu_locate #(
  parameter int unsigned DIM_MAX  = 512,
  parameter int unsigned DEST_MAX = 4096
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [bliu_pkg::STEP_W-1:0]  step_i,
  input  logic [bliu_pkg::COORD_W-1:0] coord_i,
  input  logic [bliu_pkg::DIM_W-1:0]   dim_i,
  output logic [$clog2(DIM_MAX)-1:0] i1_o,
  output logic [$clog2(DIM_MAX)-1:0] i2_o,
  output logic [bliu_pkg::FRAC_W-1:0]  w_o
);
  import bliu_pkg::*;

  localparam int unsigned IW = $clog2(DIM_MAX);
  localparam int unsigned DW = $clog2(DEST_MAX);
  localparam int unsigned PW = STEP_W + DW;

  logic [DW-1:0] dsat;
  logic [PW-1:0] pos_d, pos_q;
  logic [31:0]   ip32, dimc, coord32;
  logic [IW-1:0] i1_d, i1_q, i2_d, i2_q;

  always_comb begin
    coord32 = 32'(coord_i);
    if (coord32 >= 32'(DEST_MAX - 1)) begin
      dsat = DW'(DEST_MAX - 1);
    end else begin
      dsat = coord32[DW-1:0];
    end
    pos_d = PW'(step_i) * PW'(dsat);
  end

  always_comb begin
    ip32 = 32'(pos_q >> FRAC_W);
    if (dim_i == '0) begin
      dimc = 32'd1;
    end else if (32'(dim_i) > 32'(DIM_MAX)) begin
      dimc = 32'(DIM_MAX);
    end else begin
      dimc = 32'(dim_i);
    end
    if (ip32 >= dimc - 32'd1) begin
      i1_d = IW'(dimc - 32'd1);
      i2_d = IW'(dimc - 32'd1);
    end else begin
      i1_d = IW'(ip32);
      i2_d = IW'(ip32 + 32'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q <= pos_d;
      i1_q  <= i1_d;
      i2_q  <= i2_d;
      w_o   <= pos_q[FRAC_W-1:0];
    end
  end

  assign i1_o = i1_q;
  assign i2_o = i2_q;

endmodule

// File: src/bliu_blend.sv
// One channel of the bilinear blend: horizontal pass, then vertical pass.
// Two register stages; uses bliu_pkg.
`timescale 1ns / 1ps
module bliu_blend (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [7:0]                a_i,
  input  logic [7:0]                b_i,
  input  logic [7:0]                c_i,
  input  logic [7:0]                d_i,
  input  logic [bliu_pkg::FRAC_W-1:0] fx_i,
  input  logic [bliu_pkg::FRAC_W-1:0] fy_i,
  output logic [7:0]                pix_o
);
  import bliu_pkg::*;

  logic [16:0] wx0, wy0;
  logic [24:0] r1_d, r1_q, r2_d, r2_q;
  logic [FRAC_W-1:0] fy_q;
  logic [42:0] sum;
  logic [7:0]  pix_d, pix_q;

  always_comb begin
    wx0  = WEIGHT_ONE - {1'b0, fx_i};
    r1_d = 25'(a_i * wx0) + 25'(b_i * fx_i);
    r2_d = 25'(c_i * wx0) + 25'(d_i * fx_i);
  end

  always_comb begin
    wy0 = WEIGHT_ONE - {1'b0, fy_q};
    sum = 43'(r1_q * wy0) + 43'(r2_q * fy_q);
    if (sum[42:32] > 11'(PIX_MAX)) begin
      pix_d = PIX_MAX;
    end else begin
      pix_d = sum[39:32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q  <= r1_d;
      r2_q  <= r2_d;
      fy_q  <= fy_i;
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

// File: src/bilinear_image_upscaler.sv
// Bilinear image upscaler top level: register port, source store, pipeline.
// Coordinate mapping, source store read, then blend; one item per cycle
// sustained while the output is not stalled, set by the four-bank source store
// that reads all neighbors at once. A load gives no result. Reset clears control
// and registers to their reset values; the source store is not cleared.
`timescale 1ns / 1ps
module bilinear_image_upscaler #(
  parameter int unsigned MAX_SOURCE_WIDTH  = 512,
  parameter int unsigned MAX_SOURCE_HEIGHT = 512,
  parameter int unsigned MAX_DEST_DIM      = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [8:0]  load_x_i,
  input  logic [8:0]  load_y_i,
  input  logic [31:0] load_pixel_i,
  input  logic [11:0] sample_x_i,
  input  logic [11:0] sample_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_pixel_o
);
  import bliu_pkg::*;

  localparam int unsigned XW = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned YW = $clog2(MAX_SOURCE_HEIGHT);
  localparam int unsigned XH = (XW > 1) ? XW - 1 : 1;
  localparam int unsigned YH = (YW > 1) ? YW - 1 : 1;
  localparam int unsigned AW = XH + YH;

  // registers
  logic [DIM_W-1:0]  width_q, height_q;
  logic [STEP_W-1:0] step_x_q, step_y_q;
  logic [CH_W-1:0]   chan_q;
  logic [2:0]        rsel;

  assign pready = 1'b1;
  assign rsel   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      step_x_q <= '0;
      step_y_q <= '0;
      chan_q   <= CH_W'(4);
    end else if (psel && penable && pwrite) begin
      case (rsel)
        REG_SRC_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        REG_STEP_X:     step_x_q <= pwdata[STEP_W-1:0];
        REG_STEP_Y:     step_y_q <= pwdata[STEP_W-1:0];
        REG_CHANNELS:   chan_q   <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rsel)
      REG_SRC_WIDTH:  prdata = 32'(width_q);
      REG_SRC_HEIGHT: prdata = 32'(height_q);
      REG_STEP_X:     prdata = 32'(step_x_q);
      REG_STEP_Y:     prdata = 32'(step_y_q);
      REG_CHANNELS:   prdata = 32'(chan_q);
      default:        prdata = '0;
    endcase
  end

  // pipeline control
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  op_e  op1_q, op2_q, op3_q, op4_q, op5_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = v5_q && (op5_q == OP_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  logic [8:0]  lx1_q, ly1_q, lx2_q, ly2_q;
  logic [31:0] lp1_q, lp2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= op_e'(operation_i);
      op2_q <= op1_q;
      op3_q <= op2_q;
      op4_q <= op3_q;
      op5_q <= op4_q;
      lx1_q <= load_x_i;
      ly1_q <= load_y_i;
      lp1_q <= load_pixel_i;
      lx2_q <= lx1_q;
      ly2_q <= ly1_q;
      lp2_q <= lp1_q;
    end
  end

  // stages 1 and 2: coordinate mapping
  logic [XW-1:0] x1, x2;
  logic [YW-1:0] y1, y2;
  logic [FRAC_W-1:0] fx2, fy2;

  bliu_locate #(.DIM_MAX(MAX_SOURCE_WIDTH), .DEST_MAX(MAX_DEST_DIM)) u_loc_x (
    .clk_i, .en_i(en), .step_i(step_x_q), .coord_i(sample_x_i), .dim_i(width_q),
    .i1_o(x1), .i2_o(x2), .w_o(fx2)
  );

  bliu_locate #(.DIM_MAX(MAX_SOURCE_HEIGHT), .DEST_MAX(MAX_DEST_DIM)) u_loc_y (
    .clk_i, .en_i(en), .step_i(step_y_q), .coord_i(sample_y_i), .dim_i(height_q),
    .i1_o(y1), .i2_o(y2), .w_o(fy2)
  );

  // stage 3: four-bank store, bank = {row parity, column parity}
  logic        load_ok;
  logic [AW-1:0] waddr;
  logic [3:0]  we;
  logic [AW-1:0] raddr [4];
  logic [31:0] rdata [4];
  logic [XW-1:0] xs [2];
  logic [YW-1:0] ys [2];

  always_comb begin
    load_ok = (32'(lx2_q) < 32'(MAX_SOURCE_WIDTH)) &&
              (32'(ly2_q) < 32'(MAX_SOURCE_HEIGHT));
    waddr   = {YH'(ly2_q >> 1), XH'(lx2_q >> 1)};
    we      = '0;
    if (en && v2_q && (op2_q == OP_LOAD) && load_ok) begin
      we[{ly2_q[0], lx2_q[0]}] = 1'b1;
    end
    for (int p = 0; p < 2; p++) begin
      xs[p] = (x1[0] == p[0]) ? x1 : x2;
      ys[p] = (y1[0] == p[0]) ? y1 : y2;
    end
    for (int b = 0; b < 4; b++) begin
      raddr[b] = {YH'(ys[b/2] >> 1), XH'(xs[b%2] >> 1)};
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    bliu_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_ram (
      .clk_i, .we_i(we[g]), .waddr_i(waddr), .wdata_i(lp2_q),
      .re_i(en), .raddr_i(raddr[g]), .rdata_o(rdata[g])
    );
  end

  logic x1b_q, x2b_q, y1b_q, y2b_q;
  logic [FRAC_W-1:0] fx3_q, fy3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1b_q <= x1[0];
      x2b_q <= x2[0];
      y1b_q <= y1[0];
      y2b_q <= y2[0];
      fx3_q <= fx2;
      fy3_q <= fy2;
    end
  end

  // stages 4 and 5: blend
  logic [31:0] pa, pb, pc, pd, pix;

  assign pa = rdata[{y1b_q, x1b_q}];
  assign pb = rdata[{y1b_q, x2b_q}];
  assign pc = rdata[{y2b_q, x1b_q}];
  assign pd = rdata[{y2b_q, x2b_q}];

  for (genvar k = 0; k < 4; k++) begin : g_chan
    bliu_blend u_blend (
      .clk_i, .en_i(en),
      .a_i(pa[8*k +: 8]), .b_i(pb[8*k +: 8]), .c_i(pc[8*k +: 8]), .d_i(pd[8*k +: 8]),
      .fx_i(fx3_q), .fy_i(fy3_q), .pix_o(pix[8*k +: 8])
    );
  end

  assign result_pixel_o = {(chan_q == RGB_CHANNELS) ? 8'd0 : pix[31:24], pix[23:0]};

  // checks
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(op5_q)))
    else $error("held result lost");

  a_order_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (x1 <= x2 && y1 <= y2))
    else $error("neighbor order broken");

endmodule
